[hw/rtl/psu_pkg.sv]
// Package for the particle swarm update block: types, sizes and request codes.
// Used by particle_swarm_update, psu_grid and psu_parts.
package psu_pkg;

    localparam int NumParticles = 64;
    localparam int GridDim      = 64;
    localparam int PartIdxW     = 6;
    localparam int GridIdxW     = 6;
    localparam int GridAddrW    = 12;
    localparam int CfgIdxW      = 3;
    localparam int CfgDataW     = 20;
    localparam logic signed [31:0] OutScore = -32'sd1000000;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_PLACE = 2'd1;
    localparam logic [1:0] REQ_MOVE  = 2'd2;

    localparam logic [CfgIdxW-1:0] CFG_W  = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_C1 = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_C2 = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_R1 = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_R2 = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_GW = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_GH = 3'd6;

    // one particle record as held in the particle memory
    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] bs;
    } t_part;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'sh0_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -34'sh0_8000_0000) begin
            return -32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // integer part truncated toward zero; bit 16 of result set when the truncated result is negative
    function automatic logic signed [16:0] int_part(input logic signed [31:0] q);
        logic [31:0] m;
        m = q[31] ? (~q + 32'd1) : q;
        return q[31] ? -$signed({1'b0, m[31:16]}) : $signed({1'b0, q[31:16]});
    endfunction

endpackage

[hw/rtl/particle_swarm_update.sv]
// Particle swarm update top level: sequencer, velocity datapath and global best.
// Depends on psu_pkg, psu_grid, psu_parts.
// Throughput: one request at a time; the next is taken once the result register
// is free. A move is paced by one shared 32x34 multiplier used six times.
// Reset: synchronous active low; clears control, global best to -1000000 and
// config to defaults. Grid and particle memories are not cleared.
module particle_swarm_update (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [psu_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [psu_pkg::CfgDataW-1:0]  i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_req_type,
    input  logic [5:0]                    i_particle_index,
    input  logic [5:0]                    i_cell_col,
    input  logic [5:0]                    i_cell_row,
    input  logic signed [31:0]            i_cell_score,
    input  logic signed [31:0]            i_start_x,
    input  logic signed [31:0]            i_start_y,
    input  logic [15:0]                   i_rand_one,
    input  logic [15:0]                   i_rand_two,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [31:0]            o_particle_score,
    output logic signed [31:0]            o_particle_x,
    output logic signed [31:0]            o_particle_y,
    output logic                          o_improved_personal,
    output logic signed [31:0]            o_best_score,
    output logic signed [31:0]            o_best_x,
    output logic signed [31:0]            o_best_y
);
    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_RD    = 10'b0000000010,
        S_K     = 10'b0000000100,
        S_MUL   = 10'b0000001000,
        S_POS   = 10'b0000010000,
        S_GRD   = 10'b0000100000,
        S_SCORE = 10'b0001000000,
        S_DONE  = 10'b0010000000,
        S_PGRD  = 10'b0100000000,
        S_PSC   = 10'b1000000000
    } t_state;

    t_state r_state;
    logic signed [19:0] r_w, r_c1, r_c2;
    logic signed [17:0] r_r1, r_r2;
    logic [6:0] r_gw, r_gh;
    logic signed [31:0] r_gs, r_gx, r_gy;

    logic [5:0] r_idx;
    logic [15:0] r_ra, r_rb;
    logic signed [31:0] r_sx, r_sy;
    logic [2:0] r_step;
    logic signed [21:0] r_k1, r_k2;
    logic signed [51:0] r_acc;
    logic signed [31:0] r_nvx, r_nvy, r_npx, r_npy;
    logic r_oob;

    logic signed [31:0] r_os, r_ox, r_oy;
    logic r_oi, r_ov;

    psu_pkg::t_part w_rd, w_wd;
    logic w_pwe;
    logic signed [31:0] w_grd;
    logic w_gwe;
    logic [11:0] w_graddr;

    // grid address and range check from the candidate position
    logic signed [31:0] w_cx, w_cy;
    logic signed [16:0] w_col, w_row;
    logic [6:0] w_gwc, w_ghc;
    always_comb begin
        w_cx = (r_state == S_IDLE || r_state == S_PGRD) ? r_sx : r_npx;
        w_cy = (r_state == S_IDLE || r_state == S_PGRD) ? r_sy : r_npy;
        w_col = psu_pkg::int_part(w_cx);
        w_row = psu_pkg::int_part(w_cy);
        w_gwc = (r_gw > 7'd64) ? 7'd64 : r_gw;
        w_ghc = (r_gh > 7'd64) ? 7'd64 : r_gh;
        w_graddr = {w_row[5:0], w_col[5:0]};
    end
    logic w_oob;
    assign w_oob = w_col[16] || w_row[16] || (w_col >= $signed({10'd0, w_gwc}))
                   || (w_row >= $signed({10'd0, w_ghc}));

    logic w_acc_in, w_out_fire;
    assign o_ready = (r_state == S_IDLE) && !r_ov;
    assign w_acc_in = i_valid && o_ready;
    assign w_out_fire = r_ov && i_ready;
    assign w_gwe = w_acc_in && (i_req_type == psu_pkg::REQ_LOAD);

    // hold the particle read address on the captured index once a request is taken
    logic [5:0] w_praddr;
    assign w_praddr = (r_state == S_IDLE) ? i_particle_index : r_idx;

    psu_grid u_grid (
        .i_clk(i_clk), .i_we(w_gwe), .i_waddr({i_cell_row, i_cell_col}),
        .i_wdata(i_cell_score), .i_raddr(w_graddr), .o_rdata(w_grd)
    );
    psu_parts u_parts (
        .i_clk(i_clk), .i_we(w_pwe), .i_waddr(r_idx), .i_wdata(w_wd),
        .i_raddr(w_praddr), .o_rdata(w_rd)
    );

    // shared multiplier: operand pair chosen by step
    logic signed [31:0] w_ma;
    logic signed [33:0] w_mb;
    logic signed [65:0] w_prod;
    logic signed [49:0] w_term;
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_step)
            3'd0: begin w_ma = 32'(r_w);  w_mb = 34'(w_rd.vx); end
            3'd1: begin w_ma = 32'(r_k1); w_mb = 34'(w_rd.bx) - 34'(w_rd.px); end
            3'd2: begin w_ma = 32'(r_k2); w_mb = 34'(r_gx) - 34'(w_rd.px); end
            3'd3: begin w_ma = 32'(r_w);  w_mb = 34'(w_rd.vy); end
            3'd4: begin w_ma = 32'(r_k1); w_mb = 34'(w_rd.by) - 34'(w_rd.py); end
            3'd5: begin w_ma = 32'(r_k2); w_mb = 34'(r_gy) - 34'(w_rd.py); end
            default: begin w_ma = '0; w_mb = '0; end
        endcase
        w_prod = w_ma * w_mb;
        w_term = w_prod[65:16];
    end

    logic signed [37:0] w_k1p, w_k2p;
    logic signed [17:0] w_r1, w_r2;
    assign w_r1 = r_r1[17] ? $signed({2'b00, r_ra}) : r_r1;
    assign w_r2 = r_r2[17] ? $signed({2'b00, r_rb}) : r_r2;
    assign w_k1p = r_c1 * w_r1;
    assign w_k2p = r_c2 * w_r2;

    logic signed [51:0] w_sum;
    assign w_sum = 52'(r_acc) + 52'(w_term);
    logic signed [33:0] w_sumsat;
    assign w_sumsat = 34'(psu_pkg::sat32(
        (w_sum > 52'sh0_0000_7FFF_FFFF) ? 34'sh0_7FFF_FFFF :
        (w_sum < -52'sh0_0000_8000_0000) ? -34'sh0_8000_0000 : w_sum[33:0]));

    logic w_better;
    logic signed [31:0] w_sc;
    assign w_sc = r_oob ? psu_pkg::OutScore : w_grd;
    assign w_better = w_sc > w_rd.bs;

    always_comb begin
        w_pwe = 1'b0;
        w_wd = w_rd;
        if (r_state == S_PSC) begin
            w_pwe = 1'b1;
            w_wd.px = r_sx; w_wd.py = r_sy; w_wd.vx = '0; w_wd.vy = '0;
            w_wd.bx = r_sx; w_wd.by = r_sy; w_wd.bs = w_sc;
        end else if (r_state == S_SCORE) begin
            w_pwe = 1'b1;
            w_wd.px = r_npx; w_wd.py = r_npy; w_wd.vx = r_nvx; w_wd.vy = r_nvy;
            if (w_better) begin
                w_wd.bx = r_npx; w_wd.by = r_npy; w_wd.bs = w_sc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov <= 1'b0;
            r_w <= 20'sd45875; r_c1 <= 20'sd98304; r_c2 <= 20'sd98304;
            r_r1 <= -18'sd1; r_r2 <= -18'sd1; r_gw <= 7'd64; r_gh <= 7'd64;
            r_gs <= psu_pkg::OutScore; r_gx <= '0; r_gy <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    psu_pkg::CFG_W:  r_w  <= i_cfg_data;
                    psu_pkg::CFG_C1: r_c1 <= i_cfg_data;
                    psu_pkg::CFG_C2: r_c2 <= i_cfg_data;
                    psu_pkg::CFG_R1: r_r1 <= i_cfg_data[17:0];
                    psu_pkg::CFG_R2: r_r2 <= i_cfg_data[17:0];
                    psu_pkg::CFG_GW: r_gw <= i_cfg_data[6:0];
                    psu_pkg::CFG_GH: r_gh <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (w_out_fire) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc_in) begin
                        r_idx <= i_particle_index; r_ra <= i_rand_one;
                        r_rb <= i_rand_two;
                        r_sx <= i_start_x; r_sy <= i_start_y;
                        if (i_req_type == psu_pkg::REQ_PLACE) begin
                            r_state <= S_PGRD;
                        end else if (i_req_type == psu_pkg::REQ_MOVE) begin
                            r_state <= S_RD;
                        end else begin
                            r_state <= S_DONE;
                            r_os <= '0; r_ox <= '0; r_oy <= '0; r_oi <= 1'b0;
                        end
                    end
                end
                S_PGRD: begin
                    r_oob <= w_oob;
                    r_state <= S_PSC;
                end
                S_PSC: begin
                    r_os <= w_sc; r_ox <= r_sx; r_oy <= r_sy; r_oi <= 1'b1;
                    if (w_sc > r_gs) begin
                        r_gs <= w_sc; r_gx <= r_sx; r_gy <= r_sy;
                    end
                    r_state <= S_DONE;
                end
                S_RD: r_state <= S_K;
                S_K: begin
                    r_k1 <= w_k1p[37:16];
                    r_k2 <= w_k2p[37:16];
                    r_step <= 3'd0;
                    r_acc <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    // accumulate three terms per axis, saturate on the third
                    if (r_step == 3'd2) begin
                        r_nvx <= w_sumsat[31:0];
                        r_acc <= '0;
                    end else if (r_step == 3'd5) begin
                        r_nvy <= w_sumsat[31:0];
                        r_state <= S_POS;
                    end else begin
                        r_acc <= w_sum;
                    end
                    r_step <= r_step + 3'd1;
                end
                S_POS: begin
                    r_npx <= psu_pkg::sat32(34'(w_rd.px) + 34'(r_nvx));
                    r_npy <= psu_pkg::sat32(34'(w_rd.py) + 34'(r_nvy));
                    r_state <= S_GRD;
                end
                S_GRD: begin
                    r_oob <= w_oob;
                    r_state <= S_SCORE;
                end
                S_SCORE: begin
                    r_os <= w_sc; r_ox <= r_npx; r_oy <= r_npy; r_oi <= w_better;
                    if (w_better && w_sc > r_gs) begin
                        r_gs <= w_sc; r_gx <= r_npx; r_gy <= r_npy;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_ov <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_ov;
    assign o_particle_score = r_os;
    assign o_particle_x = r_ox;
    assign o_particle_y = r_oy;
    assign o_improved_personal = r_oi;
    assign o_best_score = r_gs;
    assign o_best_x = r_gx;
    assign o_best_y = r_gy;
endmodule

[hw/rtl/psu_grid.sv]
// Fitness grid memory: one write port for cell loads, one registered read port.
// Depends on psu_pkg.
module psu_grid (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [psu_pkg::GridAddrW-1:0]   i_waddr,
    input  logic signed [31:0]              i_wdata,
    input  logic [psu_pkg::GridAddrW-1:0]   i_raddr,
    output logic signed [31:0]              o_rdata
);
    logic signed [31:0] r_mem [psu_pkg::GridDim*psu_pkg::GridDim];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[hw/rtl/psu_parts.sv]
// Particle memory: position, velocity and personal best in one wide record.
// Depends on psu_pkg.
module psu_parts (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [psu_pkg::PartIdxW-1:0]    i_waddr,
    input  psu_pkg::t_part                  i_wdata,
    input  logic [psu_pkg::PartIdxW-1:0]    i_raddr,
    output psu_pkg::t_part                  o_rdata
);
    psu_pkg::t_part r_mem [psu_pkg::NumParticles];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[hw/rtl/psu_checker.sv]
// Port-level checker for particle_swarm_update, bound to the top level.
// Depends on nothing but the top-level ports.
module psu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic signed [31:0] o_best_score,
    input logic signed [31:0] o_particle_score
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_particle_score))
        else $error("result dropped while stalled");
    a_no_take_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("request taken while result pending");
    a_best_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> o_best_score >= $past(o_best_score))
        else $error("global best decreased");
    a_rst_best: assert property (@(posedge i_clk)
        !i_rst_n |=> o_best_score == -32'sd1000000 && !o_valid)
        else $error("reset state wrong");
endmodule

bind particle_swarm_update psu_checker u_psu_checker (.*);
